>>> rtl/core/nsc_pkg.sv
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared types, character codes, talker and sentence ID tables, status codes.
// ----------------------------------------------------------------------------
package nsc_pkg;

  // Framing characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_STAR   = 8'h2A;

  // Header capture depth (characters at positions 1..5)
  localparam int HDR_DEPTH = 5;
  localparam int POS_W     = 3;
  localparam logic [POS_W-1:0] POS_SAT = 3'd6;

  // Talker list in priority order: II WI GP GN BD GA P
  localparam int NUM_TALKERS = 7;
  localparam logic [7:0] TALKER_C0 [NUM_TALKERS] = '{"I", "W", "G", "G", "B", "G", "P"};
  localparam logic [7:0] TALKER_C1 [NUM_TALKERS] = '{"I", "I", "P", "N", "D", "A", CH_NUL};
  // Single-letter talker (proprietary)
  localparam logic [2:0] SRC_P    = 3'd6;
  localparam logic [2:0] SRC_NONE = 3'd7;

  // Sentence IDs: parsed first, then known but unparsed
  localparam int NUM_IDS    = 9;
  localparam int NUM_PARSED = 6;
  localparam logic [23:0] ID_TEXT [NUM_IDS] = '{
    "GGA", "GLL", "GSA", "RMC", "TXT", "GSV", "DBT", "HDM", "HDT"
  };
  localparam logic [3:0] SID_NONE = 4'd9;

  // Verdict codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_START  = 3'd1;
  localparam logic [2:0] ST_NO_STAR    = 3'd2;
  localparam logic [2:0] ST_BAD_SUM    = 3'd3;
  localparam logic [2:0] ST_NO_SOURCE  = 3'd4;
  localparam logic [2:0] ST_KNOWN      = 3'd5;
  localparam logic [2:0] ST_UNKNOWN_ID = 3'd6;

  // Sentence state as seen by the verdict logic
  typedef struct packed {
    logic                      start_ok;
    logic                      star_seen;
    logic [7:0]                xor_before_star;
    logic [7:0]                checksum;
    logic [HDR_DEPTH-1:0][7:0] hdr;
  } sent_t;

  // One verdict
  typedef struct packed {
    logic [3:0] sentence_index;
    logic [2:0] source_index;
    logic [2:0] status;
  } res_t;

  // Uppercase hex digit value; anything else counts as zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= "0" && c <= "9") begin
      v = 4'(c - "0");
    end else if (c >= "A" && c <= "F") begin
      v = 4'(c - "A" + 8'd10);
    end
    return v;
  endfunction

endpackage

>>> rtl/core/nsc_accum.sv
// ----------------------------------------------------------------------------
// nsc_accum
// Per-sentence state: start check, running XOR, checksum digits, header bytes.
// ----------------------------------------------------------------------------
module nsc_accum (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic [7:0]    char_byte,
  input  logic          last,
  output nsc_pkg::sent_t view
);
  import nsc_pkg::*;

  logic [POS_W-1:0]          pos_r,   pos_nxt;
  logic                      start_r, start_nxt;
  logic [7:0]                xor_r,   xor_nxt;
  logic [7:0]                xbs_r,   xbs_nxt;
  logic                      star_r,  star_nxt;
  logic [1:0]                dig_r,   dig_nxt;
  logic [7:0]                sum_r,   sum_nxt;
  logic [HDR_DEPTH-1:0][7:0] hdr_r,   hdr_nxt;
  logic                      term_r,  term_nxt;

  // Fold one character into the sentence state
  always_comb begin
    pos_nxt   = pos_r;
    start_nxt = start_r;
    xor_nxt   = xor_r;
    xbs_nxt   = xbs_r;
    star_nxt  = star_r;
    dig_nxt   = dig_r;
    sum_nxt   = sum_r;
    hdr_nxt   = hdr_r;
    term_nxt  = term_r;
    if (!term_r) begin
      if (char_byte == CH_NUL) begin
        term_nxt = 1'b1;
      end else begin
        if (pos_r == '0) begin
          start_nxt = (char_byte == CH_DOLLAR) || (char_byte == CH_BANG);
        end else begin
          for (int i = 0; i < HDR_DEPTH; i++) begin
            if (pos_r == POS_W'(i + 1)) begin
              hdr_nxt[i] = char_byte;
            end
          end
          if (char_byte == CH_STAR) begin
            xbs_nxt  = xor_r;
            star_nxt = 1'b1;
            dig_nxt  = 2'd0;
            sum_nxt  = 8'd0;
          end else if (star_r && dig_r != 2'd2) begin
            if (dig_r == 2'd0) begin
              sum_nxt = {hex_value(char_byte), 4'd0};
            end else begin
              sum_nxt = {sum_r[7:4], hex_value(char_byte)};
            end
            dig_nxt = dig_r + 2'd1;
          end
          xor_nxt = xor_r ^ char_byte;
        end
        if (pos_r != POS_SAT) begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
    end
  end

  // State including the current character, for the verdict
  assign view.start_ok        = start_nxt;
  assign view.star_seen       = star_nxt;
  assign view.xor_before_star = xbs_nxt;
  assign view.checksum        = sum_nxt;
  assign view.hdr             = hdr_nxt;

  // Advance on each request; clear after the final character
  always_ff @(posedge clk) begin
    if (!rst_n || (step && last)) begin
      pos_r   <= '0;
      start_r <= 1'b0;
      xor_r   <= 8'd0;
      xbs_r   <= 8'd0;
      star_r  <= 1'b0;
      dig_r   <= 2'd0;
      sum_r   <= 8'd0;
      hdr_r   <= '0;
      term_r  <= 1'b0;
    end else if (step) begin
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      xor_r   <= xor_nxt;
      xbs_r   <= xbs_nxt;
      star_r  <= star_nxt;
      dig_r   <= dig_nxt;
      sum_r   <= sum_nxt;
      hdr_r   <= hdr_nxt;
      term_r  <= term_nxt;
    end
  end

endmodule

>>> rtl/core/nsc_verdict.sv
// ----------------------------------------------------------------------------
// nsc_verdict
// Classify a finished sentence: framing, checksum, talker and sentence ID.
// ----------------------------------------------------------------------------
module nsc_verdict (
  input  nsc_pkg::sent_t s,
  output nsc_pkg::res_t  r
);
  import nsc_pkg::*;

  logic        src_hit;
  logic [2:0]  src;
  logic [23:0] id_win;
  logic        sid_hit;
  logic [3:0]  sid;

  // First talker that matches, in list order
  always_comb begin
    src_hit = 1'b0;
    src     = SRC_NONE;
    for (int i = 0; i < NUM_TALKERS; i++) begin
      if (!src_hit && s.hdr[0] == TALKER_C0[i] &&
          (3'(i) == SRC_P || s.hdr[1] == TALKER_C1[i])) begin
        src_hit = 1'b1;
        src     = 3'(i);
      end
    end
  end

  // Sentence ID window follows the talker
  assign id_win = (src == SRC_P) ? {s.hdr[1], s.hdr[2], s.hdr[3]}
                                 : {s.hdr[2], s.hdr[3], s.hdr[4]};

  // First sentence ID that matches
  always_comb begin
    sid_hit = 1'b0;
    sid     = SID_NONE;
    for (int i = 0; i < NUM_IDS; i++) begin
      if (!sid_hit && id_win == ID_TEXT[i]) begin
        sid_hit = 1'b1;
        sid     = 4'(i);
      end
    end
  end

  // Priority of checks
  always_comb begin
    r.source_index   = SRC_NONE;
    r.sentence_index = SID_NONE;
    if (!s.start_ok) begin
      r.status = ST_BAD_START;
    end else if (!s.star_seen) begin
      r.status = ST_NO_STAR;
    end else if (s.xor_before_star != s.checksum) begin
      r.status = ST_BAD_SUM;
    end else if (!src_hit) begin
      r.status = ST_NO_SOURCE;
    end else begin
      r.source_index = src;
      if (!sid_hit) begin
        r.status = ST_UNKNOWN_ID;
      end else begin
        r.sentence_index = sid;
        r.status = (sid < 4'(NUM_PARSED)) ? ST_OK : ST_KNOWN;
      end
    end
  end

endmodule

>>> rtl/core/nmea_sentence_checker.sv
// ----------------------------------------------------------------------------
// nmea_sentence_checker
// Checks NMEA 0183 sentences streamed one character per request and gives
// one verdict per sentence.
//
//   channel  dir  contents
//   in_*     in   tdata = char_byte, tlast = end_of_sentence
//   out_*    out  tdata = status, source_index, sentence_index
//
// One character per cycle while no stalled verdict holds a final character. A
// character waits in the input register; the verdict is registered at the
// edge where the final character leaves the input register. Reset clears
// all sentence state and both valid flags. A stalled verdict holds only the
// input register when it carries a final character; other characters keep
// flowing.
// ----------------------------------------------------------------------------
module nmea_sentence_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tlast,   // end_of_sentence
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [2:0] status, [5:3] source_index,
                                  // [9:6] sentence_index, [15:10] zero
);
  import nsc_pkg::*;

  logic           s1_valid_r, s1_valid_nxt;
  logic [7:0]     s1_byte_r;
  logic           s1_last_r;
  logic           s1_adv;
  logic           in_acc;
  logic           out_valid_r, out_valid_nxt;
  res_t           res_r;
  res_t           res;
  sent_t          view;

  // Input register moves on unless its verdict cannot be placed
  assign s1_adv    = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture request payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  nsc_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .char_byte (s1_byte_r),
    .last      (s1_last_r),
    .view      (view)
  );

  nsc_verdict u_verdict (
    .s (view),
    .r (res)
  );

  // Load verdict on the final character
  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, res_r.sentence_index, res_r.source_index, res_r.status};

endmodule

>>> rtl/core/nsc_checker.sv
// ----------------------------------------------------------------------------
// nsc_checker
// Port-level checks on the verdict stream of the sentence checker.
// ----------------------------------------------------------------------------
module nsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);
  import nsc_pkg::*;

  logic [2:0] st;
  logic [2:0] src;
  logic [3:0] sid;

  assign st  = out_tdata[2:0];
  assign src = out_tdata[5:3];
  assign sid = out_tdata[9:6];

  // Stalled verdict holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("verdict changed while stalled");

  // Early failures carry no talker and no sentence ID
  a_early: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (st == ST_BAD_START || st == ST_NO_STAR || st == ST_BAD_SUM ||
                   st == ST_NO_SOURCE) |-> src == SRC_NONE && sid == SID_NONE)
    else $error("early failure with talker or sentence ID");

  // Unknown ID keeps a talker but no sentence ID
  a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == ST_UNKNOWN_ID |-> src != SRC_NONE && sid == SID_NONE)
    else $error("unknown ID verdict malformed");

  // Parsed and known IDs land in their own ranges
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (st == ST_OK || st == ST_KNOWN) |->
      src != SRC_NONE && (st == ST_OK ? sid < 4'(NUM_PARSED)
                                      : (sid >= 4'(NUM_PARSED) && sid < SID_NONE)))
    else $error("sentence ID outside its class");

  // Padding bits stay zero and no undefined code appears
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:10] == 6'd0 && st != 3'd7)
    else $error("bad verdict encoding");

endmodule

bind nmea_sentence_checker nsc_checker u_nsc_checker (.*);
